[rtl/bodi_pkg.sv]
// Shared constants, widths and helper functions for the bicycle odometry integrator.
package bodi_pkg;

    localparam int RATE_W  = 24;
    localparam int STEER_W = 16;
    localparam int DT_W    = 20;
    localparam int REG_W   = 16;
    localparam int OUT_W   = 32;

    localparam int CORDIC_STEPS = 24;

    localparam logic [REG_W-1:0] RADIUS_RST = 16'd4096;
    localparam logic [REG_W-1:0] BASE_RST   = 16'd4096;
    localparam logic signed [OUT_W-1:0] X_RST = 32'sd0;
    localparam logic signed [OUT_W-1:0] Y_RST = 32'sd327680;

    // Scale factors: steer Q3.13 to binary angle, rad Q.27 to binary angle, microseconds.
    localparam logic [63:0] K_STEER  = 64'd5468522205;
    localparam logic [63:0] K_HEAD   = 64'd85445659;
    localparam logic [63:0] DT_SCALE = 64'd1000000;

    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    localparam logic CFG_RADIUS = 1'b0;
    localparam logic CFG_BASE   = 1'b1;

    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051D;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2E;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000028;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000002;
            5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [31:0] r;
        if (v > 65'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -65'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[rtl/bodi_in_if.sv]
// Input sample channel: wheel rates, steer angles and elapsed time.
interface bodi_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [bodi_pkg::RATE_W-1:0]    left_rate;
    logic signed [bodi_pkg::RATE_W-1:0]    right_rate;
    logic signed [bodi_pkg::STEER_W-1:0]   left_steer;
    logic signed [bodi_pkg::STEER_W-1:0]   right_steer;
    logic        [bodi_pkg::DT_W-1:0]      time_step;

    modport source(output valid, left_rate, right_rate, left_steer, right_steer, time_step,
                   input ready);
    modport sink(input valid, left_rate, right_rate, left_steer, right_steer, time_step,
                 output ready);
endinterface

[rtl/bodi_out_if.sv]
// Result channel: pose, speed and yaw rate.
interface bodi_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [bodi_pkg::OUT_W-1:0]   pos_x;
    logic signed [bodi_pkg::OUT_W-1:0]   pos_y;
    logic        [bodi_pkg::OUT_W-1:0]   heading_out;
    logic signed [bodi_pkg::OUT_W-1:0]   speed;
    logic signed [bodi_pkg::OUT_W-1:0]   yaw_rate;

    modport source(output valid, pos_x, pos_y, heading_out, speed, yaw_rate, input ready);
    modport sink(input valid, pos_x, pos_y, heading_out, speed, yaw_rate, output ready);
endinterface

[rtl/bicycle_odometry_integrator_top.sv]
// Bicycle-model odometry integrator: sequencer around a bit-serial multiplier, divider and CORDIC.
// Each sample passes through the shared one-bit-per-cycle multiplier (its length follows the
// bit length of the second operand), the 64-step restoring divider (used up to four times) and
// two CORDIC runs of CORDIC_STEPS iterations. One sample is processed at a time, and the
// next request is taken while a finished result still waits. Synchronous active-low reset
// restores the default radius, base and the start pose.
module bicycle_odometry_integrator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [bodi_pkg::REG_W-1:0]    i_cfg_data,
    bodi_in_if.sink                       i_in,
    bodi_out_if.source                    o_res
);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_SPD  = 5'd1;
    localparam logic [4:0] ST_ANG  = 5'd2;
    localparam logic [4:0] ST_CS1  = 5'd3;
    localparam logic [4:0] ST_DEN  = 5'd4;
    localparam logic [4:0] ST_NUM  = 5'd5;
    localparam logic [4:0] ST_YAW  = 5'd6;
    localparam logic [4:0] ST_CS2  = 5'd7;
    localparam logic [4:0] ST_PX   = 5'd8;
    localparam logic [4:0] ST_DX   = 5'd9;
    localparam logic [4:0] ST_DXD  = 5'd10;
    localparam logic [4:0] ST_PY   = 5'd11;
    localparam logic [4:0] ST_DY   = 5'd12;
    localparam logic [4:0] ST_DYD  = 5'd13;
    localparam logic [4:0] ST_R    = 5'd14;
    localparam logic [4:0] ST_RD   = 5'd15;
    localparam logic [4:0] ST_INC  = 5'd16;
    localparam logic [4:0] ST_OUT  = 5'd17;

    logic [4:0]          r_step;
    logic                r_busy;
    logic [6:0]          r_cnt;
    logic [15:0]         r_radius;
    logic [15:0]         r_base;
    logic signed [31:0]  r_xpos;
    logic signed [31:0]  r_ypos;
    logic [31:0]         r_head;

    logic signed [24:0]  r_rsum;
    logic signed [16:0]  r_ssum;
    logic [19:0]         r_dt;
    logic signed [31:0]  r_speed;
    logic signed [31:0]  r_yaw;
    logic [31:0]         r_ang;
    logic [31:0]         r_inc;
    logic signed [33:0]  r_sn;
    logic signed [33:0]  r_cs;
    logic signed [63:0]  r_den;
    logic signed [63:0]  r_num;
    logic signed [63:0]  r_t;
    logic signed [63:0]  r_dx;
    logic signed [63:0]  r_dy;

    logic signed [63:0]  r_ma;
    logic signed [63:0]  r_acc;
    logic [63:0]         r_mb;

    logic [63:0]         r_dn;
    logic [63:0]         r_dd;
    logic [63:0]         r_q;
    logic [64:0]         r_rem;
    logic                r_dneg;

    logic signed [33:0]  r_cx;
    logic signed [33:0]  r_cy;
    logic signed [33:0]  r_cz;
    logic                r_flip;

    logic                r_ovalid;
    logic signed [31:0]  r_o_x;
    logic signed [31:0]  r_o_y;
    logic [31:0]         r_o_head;
    logic signed [31:0]  r_o_speed;
    logic signed [31:0]  r_o_yaw;

    logic                is_mul;
    logic                is_div;
    logic                is_cor;
    logic signed [63:0]  mul_a;
    logic [63:0]         mul_b;
    logic signed [63:0]  div_n;
    logic signed [63:0]  div_d;
    logic [31:0]         cor_ang;
    logic                spd_neg;
    logic [63:0]         spd_mag;
    logic [63:0]         div_nmag;
    logic [63:0]         div_dmag;
    logic signed [63:0]  div_res;
    logic [64:0]         rem_sh;
    logic [64:0]         rem_sub;
    logic                rem_ge;
    logic signed [33:0]  cor_s;
    logic signed [33:0]  cor_c;
    logic signed [33:0]  cor_xsh;
    logic signed [33:0]  cor_ysh;
    logic signed [33:0]  cor_at;
    logic signed [33:0]  cor_z0;
    logic signed [33:0]  cor_zl;
    logic                cor_fl;
    logic                mul_done;
    logic                div_done;
    logic                cor_done;
    logic signed [31:0]  new_x;
    logic signed [31:0]  new_y;

    assign spd_neg = r_speed[31];
    assign spd_mag = spd_neg ? -64'(r_speed) : 64'(r_speed);

    // Operand selection for the unit that the current step uses.
    always_comb begin
        is_mul  = 1'b0;
        is_div  = 1'b0;
        is_cor  = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        div_n   = '0;
        div_d   = '0;
        cor_ang = '0;
        case (r_step)
            ST_SPD: begin
                is_mul = 1'b1;
                mul_a  = 64'(r_rsum);
                mul_b  = 64'(r_radius);
            end
            ST_ANG: begin
                is_mul = 1'b1;
                mul_a  = 64'(r_ssum);
                mul_b  = bodi_pkg::K_STEER;
            end
            ST_CS1: begin
                is_cor  = 1'b1;
                cor_ang = r_ang;
            end
            ST_DEN: begin
                is_mul = 1'b1;
                mul_a  = 64'(r_cs);
                mul_b  = 64'(r_base);
            end
            ST_NUM: begin
                is_mul = 1'b1;
                mul_a  = spd_neg ? -64'(r_sn) : 64'(r_sn);
                mul_b  = spd_mag;
            end
            ST_YAW: begin
                is_div = 1'b1;
                div_n  = r_num;
                div_d  = r_den;
            end
            ST_CS2: begin
                is_cor  = 1'b1;
                cor_ang = r_head;
            end
            ST_PX: begin
                is_mul = 1'b1;
                mul_a  = spd_neg ? -64'(r_cs) : 64'(r_cs);
                mul_b  = spd_mag;
            end
            ST_PY: begin
                is_mul = 1'b1;
                mul_a  = spd_neg ? -64'(r_sn) : 64'(r_sn);
                mul_b  = spd_mag;
            end
            ST_DX, ST_DY, ST_INC: begin
                is_mul = 1'b1;
                mul_a  = r_t;
                mul_b  = (r_step == ST_INC) ? bodi_pkg::K_HEAD : 64'(r_dt);
            end
            ST_R: begin
                is_mul = 1'b1;
                mul_a  = 64'(r_yaw);
                mul_b  = 64'(r_dt);
            end
            ST_DXD, ST_DYD, ST_RD: begin
                is_div = 1'b1;
                div_n  = r_t;
                div_d  = $signed(bodi_pkg::DT_SCALE);
            end
            default: begin
            end
        endcase
    end

    assign div_nmag = div_n[63] ? 64'(-div_n) : 64'(div_n);
    assign div_dmag = div_d[63] ? 64'(-div_d) : 64'(div_d);
    assign div_res  = r_dneg ? -$signed(r_q) : $signed(r_q);
    assign rem_sh   = {r_rem[63:0], r_dn[63]};
    assign rem_ge   = rem_sh >= {1'b0, r_dd};
    assign rem_sub  = rem_sh - {1'b0, r_dd};

    assign cor_xsh = r_cx >>> r_cnt[4:0];
    assign cor_ysh = r_cy >>> r_cnt[4:0];
    assign cor_at  = $signed({2'b00, bodi_pkg::atan_lut(r_cnt[4:0])});
    assign cor_s   = r_flip ? -r_cy : r_cy;
    assign cor_c   = r_flip ? -r_cx : r_cx;

    // Fold the angle into the right half-plane; the result is negated at the end.
    always_comb begin
        cor_z0 = 34'($signed(cor_ang));
        cor_zl = cor_z0;
        cor_fl = 1'b0;
        if (cor_z0 > 34'sd1073741824) begin
            cor_zl = cor_z0 - 34'sd2147483648;
            cor_fl = 1'b1;
        end else if (cor_z0 < -34'sd1073741824) begin
            cor_zl = cor_z0 + 34'sd2147483648;
            cor_fl = 1'b1;
        end
    end

    assign mul_done = r_busy && is_mul && (r_mb == 64'd0);
    assign div_done = r_busy && is_div && (r_cnt == 7'd64);
    assign cor_done = r_busy && is_cor && (r_cnt == 7'(bodi_pkg::CORDIC_STEPS));

    assign new_x = bodi_pkg::sat32(65'(r_xpos) + 65'(r_dx));
    assign new_y = bodi_pkg::sat32(65'(r_ypos) + 65'(r_dy));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= ST_IDLE;
            r_busy   <= 1'b0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_radius <= bodi_pkg::RADIUS_RST;
            r_base   <= bodi_pkg::BASE_RST;
            r_xpos   <= bodi_pkg::X_RST;
            r_ypos   <= bodi_pkg::Y_RST;
            r_head   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bodi_pkg::CFG_RADIUS: r_radius <= i_cfg_data;
                    bodi_pkg::CFG_BASE:   r_base   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // A result loaded in the final step keeps the register full.
            if (r_ovalid && o_res.ready && r_step != ST_OUT) begin
                r_ovalid <= 1'b0;
            end

            if (r_step == ST_IDLE) begin
                if (i_in.valid) begin
                    r_rsum <= 25'(i_in.left_rate) + 25'(i_in.right_rate);
                    r_ssum <= 17'(i_in.left_steer) + 17'(i_in.right_steer);
                    r_dt   <= i_in.time_step;
                    r_step <= ST_SPD;
                end
            end else if (r_step == ST_OUT) begin
                if (!r_ovalid || o_res.ready) begin
                    r_xpos    <= new_x;
                    r_ypos    <= new_y;
                    r_head    <= r_head + r_inc;
                    r_o_x     <= new_x;
                    r_o_y     <= new_y;
                    r_o_head  <= r_head + r_inc;
                    r_o_speed <= r_speed;
                    r_o_yaw   <= r_yaw;
                    r_ovalid  <= 1'b1;
                    r_step    <= ST_IDLE;
                end
            end else if (!r_busy) begin
                if (r_step == ST_YAW && r_den == 64'sd0) begin
                    // Divisor vanishes at a right-angle steer: saturate toward the numerator.
                    if (r_num > 64'sd0) begin
                        r_yaw <= 32'sh7FFFFFFF;
                    end else if (r_num < 64'sd0) begin
                        r_yaw <= 32'sh80000000;
                    end else begin
                        r_yaw <= 32'sd0;
                    end
                    r_step <= r_step + 5'd1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= '0;
                    r_ma   <= mul_a;
                    r_mb   <= mul_b;
                    r_acc  <= '0;
                    r_dn   <= div_nmag;
                    r_dd   <= div_dmag;
                    r_rem  <= '0;
                    r_q    <= '0;
                    r_dneg <= div_n[63] ^ div_d[63];
                    r_cx   <= bodi_pkg::CORDIC_X0;
                    r_cy   <= '0;
                    r_cz   <= cor_zl;
                    r_flip <= cor_fl;
                end
            end else if (mul_done || div_done || cor_done) begin
                r_busy <= 1'b0;
                r_step <= r_step + 5'd1;
                case (r_step)
                    ST_SPD:         r_speed <= bodi_pkg::sat32(65'(r_acc >>> 9));
                    ST_ANG:         r_ang   <= r_acc[47:16];
                    ST_CS1, ST_CS2: begin
                        r_sn <= cor_s;
                        r_cs <= cor_c;
                    end
                    ST_DEN:         r_den   <= r_acc >>> 12;
                    ST_NUM:         r_num   <= r_acc;
                    ST_YAW:         r_yaw   <= bodi_pkg::sat32(65'(div_res));
                    ST_PX, ST_PY:   r_t     <= r_acc >>> 30;
                    ST_DX, ST_DY:   r_t     <= r_acc;
                    ST_DXD:         r_dx    <= div_res;
                    ST_DYD:         r_dy    <= div_res;
                    ST_R:           r_t     <= r_acc <<< 11;
                    ST_RD:          r_t     <= div_res;
                    ST_INC:         r_inc   <= r_acc[55:24];
                    default: begin
                    end
                endcase
            end else begin
                if (is_mul) begin
                    if (r_mb[0]) begin
                        r_acc <= r_acc + r_ma;
                    end
                    r_ma <= r_ma <<< 1;
                    r_mb <= r_mb >> 1;
                end
                if (is_div) begin
                    r_rem <= rem_ge ? rem_sub : rem_sh;
                    r_q   <= {r_q[62:0], rem_ge};
                    r_dn  <= r_dn << 1;
                    r_cnt <= r_cnt + 7'd1;
                end
                if (is_cor) begin
                    if (!r_cz[33]) begin
                        r_cx <= r_cx - cor_ysh;
                        r_cy <= r_cy + cor_xsh;
                        r_cz <= r_cz - cor_at;
                    end else begin
                        r_cx <= r_cx + cor_ysh;
                        r_cy <= r_cy - cor_xsh;
                        r_cz <= r_cz + cor_at;
                    end
                    r_cnt <= r_cnt + 7'd1;
                end
            end
        end
    end

    assign i_in.ready        = (r_step == ST_IDLE);
    assign o_res.valid       = r_ovalid;
    assign o_res.pos_x       = r_o_x;
    assign o_res.pos_y       = r_o_y;
    assign o_res.heading_out = r_o_head;
    assign o_res.speed       = r_o_speed;
    assign o_res.yaw_rate    = r_o_yaw;

    a_idle_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_IDLE) |-> !r_busy)
        else $error("arithmetic unit busy while no sample is in progress");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_OUT && (!r_ovalid || o_res.ready)) |=> (r_ovalid && r_step == ST_IDLE))
        else $error("finished sample did not reach the output register");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && is_div) |-> (r_cnt <= 7'd64))
        else $error("divider ran past its last quotient bit");

    a_cordic_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && is_cor) |-> (r_cnt <= 7'(bodi_pkg::CORDIC_STEPS)))
        else $error("CORDIC ran past its iteration count");

endmodule
